// File: design/quoted_command_tokenizer_macros.svh
// Assertion macros for the quoted command tokenizer.
`ifndef QUOTED_COMMAND_TOKENIZER_MACROS_SVH
`define QUOTED_COMMAND_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define QCT_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("qct assertion failed");
// Implication checked at every clock edge outside reset.
`define QCT_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("qct implication failed");
`else
`define QCT_ASSERT(label, cond)
`define QCT_ASSERT_IMP(label, pre, post)
`endif

`endif

// File: design/qct_pkg.sv
// Shared types and constants for the quoted command tokenizer.
`default_nettype none

package qct_pkg;

  localparam int MAX_TOKEN_LEN = 1024;
  localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
  localparam int SEP_NUM       = 6;
  localparam int SEP_CNT_W     = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CHAR_W        = 8;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SEP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_CHAR0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_CHAR5 = 3'd6;

  localparam logic [SEP_CNT_W-1:0] SEP_COUNT_RST = 3'd2;
  localparam logic [CHAR_W-1:0]    SEP_CHAR0_RST = 8'd32;
  localparam logic [CHAR_W-1:0]    SEP_CHAR1_RST = 8'd9;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BEL    = 8'h07;
  localparam logic [CHAR_W-1:0] CH_LOW_R  = 8'h72;
  localparam logic [CHAR_W-1:0] CH_LOW_N  = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_LOW_T  = 8'h74;
  localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_PLAIN = 4'b0010,
    MODE_QUOTE = 4'b0100,
    MODE_ESC   = 4'b1000
  } mode_t;

  // Character class of one input byte.
  typedef struct packed {
    logic              is_sep;
    logic              is_quote;
    logic              is_bslash;
    logic              is_eol;
    logic              esc_hit;
    logic [CHAR_W-1:0] esc_char;
  } char_class_t;

endpackage

`default_nettype wire

// File: design/qct_classify.sv
// Byte classifier: separator match, quote and line-end detection, escape decode.
`default_nettype none

module qct_classify (
  input  wire logic [qct_pkg::CHAR_W-1:0]                        in_char,
  input  wire logic [qct_pkg::SEP_CNT_W-1:0]                     sep_count,
  input  wire logic [qct_pkg::SEP_NUM-1:0][qct_pkg::CHAR_W-1:0]  sep_chars,
  output qct_pkg::char_class_t                                   cls
);
  import qct_pkg::*;

  logic [SEP_NUM-1:0] sep_hit;

  // A count of seven enables all six registers, same as six.
  always_comb begin
    for (int i = 0; i < SEP_NUM; i++) begin
      sep_hit[i] = (SEP_CNT_W'(i) < sep_count) && (sep_chars[i] == in_char);
    end
  end

  always_comb begin
    cls.is_sep    = |sep_hit;
    cls.is_quote  = (in_char == CH_QUOTE);
    cls.is_bslash = (in_char == CH_BSLASH);
    cls.is_eol    = (in_char == CH_LF) || (in_char == CH_CR);
    cls.esc_hit   = 1'b1;
    unique case (in_char)
      CH_BSLASH: cls.esc_char = CH_BSLASH;
      CH_QUOTE:  cls.esc_char = CH_QUOTE;
      CH_LOW_R:  cls.esc_char = CH_CR;
      CH_LOW_N:  cls.esc_char = CH_LF;
      CH_LOW_T:  cls.esc_char = CH_TAB;
      CH_LOW_A:  cls.esc_char = CH_BEL;
      default: begin
        cls.esc_hit  = 1'b0;
        cls.esc_char = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/quoted_command_tokenizer.sv
// Top level of the quoted command tokenizer.
`default_nettype none
`include "quoted_command_tokenizer_macros.svh"

// Splits a byte stream into tokens, one byte in and one result out per transfer.
// Bytes matching any of the first sep_count separator registers split plain
// tokens; a double quote opens a quoted token in which backslash escapes give
// backslash, quote, CR, LF, TAB or BEL (unknown escapes are dropped), and a
// closing quote, CR or LF ends it, yielding an empty token for an empty pair.
// Each result carries an optional token byte (char_valid/out_char), token_end
// when the current token is complete, and string_done echoing last. Bytes past
// MAX_TOKEN_LEN in one token are dropped. Throughput is one byte per cycle
// while out_stall is low: a byte sits in an input register, is classified
// and folded combinationally into the parse state, and lands in the result
// register. The input register doubles as a skid stage, so a new byte is
// taken while a finished result waits downstream; in_stall rises only when
// both registers are full and out_stall is high. Configuration writes are
// meant for idle periods only.
module quoted_command_tokenizer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [qct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [qct_pkg::CHAR_W-1:0]      cfg_data,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [qct_pkg::CHAR_W-1:0]      in_char,
  input  wire logic                            last,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 char_valid,
  output logic [qct_pkg::CHAR_W-1:0]           out_char,
  output logic                                 token_end,
  output logic                                 string_done
);
  import qct_pkg::*;

  // configuration registers
  logic [SEP_CNT_W-1:0]            sep_count;
  logic [SEP_NUM-1:0][CHAR_W-1:0]  sep_chars;

  // input register
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_last;

  // parse state
  mode_t             mode, mode_next;
  logic [LEN_W-1:0]  token_length, token_length_next;

  char_class_t       cls;
  logic              advance;
  logic              append;
  logic [CHAR_W-1:0] append_char;
  logic              cv_next;
  logic [CHAR_W-1:0] oc_next;
  logic              tend_next;

  // Result register free, or being drained this cycle.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  qct_classify u_classify (
    .in_char   (s1_char),
    .sep_count (sep_count),
    .sep_chars (sep_chars),
    .cls       (cls)
  );

  // Parse step for the byte in the input register.
  always_comb begin
    mode_next         = mode;
    token_length_next = token_length;
    append            = 1'b0;
    append_char       = s1_char;
    tend_next         = 1'b0;
    unique case (mode)
      MODE_IDLE: begin
        // quote beats a separator that equals it
        if (cls.is_quote) begin
          mode_next = MODE_QUOTE;
        end else if (!cls.is_sep) begin
          append    = 1'b1;
          mode_next = MODE_PLAIN;
        end
      end
      MODE_PLAIN: begin
        if (cls.is_sep) begin
          tend_next         = 1'b1;
          token_length_next = '0;
          mode_next         = MODE_IDLE;
        end else if (cls.is_quote) begin
          tend_next         = 1'b1;
          token_length_next = '0;
          mode_next         = MODE_QUOTE;
        end else begin
          append = 1'b1;
        end
      end
      MODE_QUOTE: begin
        if (cls.is_quote || cls.is_eol) begin
          tend_next         = 1'b1;
          token_length_next = '0;
          mode_next         = MODE_IDLE;
        end else if (cls.is_bslash) begin
          mode_next = MODE_ESC;
        end else begin
          append = 1'b1;
        end
      end
      MODE_ESC: begin
        mode_next   = MODE_QUOTE;
        append      = cls.esc_hit;
        append_char = cls.esc_char;
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase

    // length cap: extra bytes are dropped, mode still moves
    cv_next = append && (token_length < LEN_W'(MAX_TOKEN_LEN));
    oc_next = cv_next ? append_char : '0;
    if (cv_next) begin
      token_length_next = token_length + LEN_W'(1);
    end

    // end of string: close a non-empty open token, then back to idle
    if (s1_last) begin
      if ((mode_next != MODE_IDLE) && (token_length_next != '0)) begin
        tend_next = 1'b1;
      end
      mode_next         = MODE_IDLE;
      token_length_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_count    <= SEP_COUNT_RST;
      sep_chars    <= {{((SEP_NUM - 2) * CHAR_W){1'b0}}, SEP_CHAR1_RST, SEP_CHAR0_RST};
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      mode         <= MODE_IDLE;
      token_length <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SEP_COUNT) begin
          sep_count <= cfg_data[SEP_CNT_W-1:0];
        end else if (cfg_index <= REG_SEP_CHAR5) begin
          sep_chars[cfg_index - REG_SEP_CHAR0] <= cfg_data;
        end
      end
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          mode         <= mode_next;
          token_length <= token_length_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char <= in_char;
      s1_last <= last;
    end
    if (advance && s1_valid) begin
      char_valid  <= cv_next;
      out_char    <= oc_next;
      token_end   <= tend_next;
      string_done <= s1_last;
    end
  end

  `QCT_ASSERT(a_len_cap, token_length <= LEN_W'(MAX_TOKEN_LEN))
  `QCT_ASSERT_IMP(a_idle_len_zero, mode == MODE_IDLE, token_length == '0)
  `QCT_ASSERT_IMP(a_stall_only_full, in_stall, s1_valid && out_valid && out_stall)
  `QCT_ASSERT_IMP(a_char_in_token, out_valid && char_valid && !string_done, mode != MODE_IDLE)
  `QCT_ASSERT_IMP(a_zero_no_char, out_valid && !char_valid, out_char == '0)

endmodule

`default_nettype wire

// File: tb/quoted_command_tokenizer_tb.sv
// Self-checking testbench for the quoted command tokenizer.
`default_nettype none

module quoted_command_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qct_pkg::*;

  // Index 7 has no register behind it; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  // Slowest run is roughly 4k bytes; this limit leaves it a wide margin.
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_PHASES = 6;
  localparam int BYTES_PER_PHASE = 135;

  typedef logic [CHAR_W-1:0] byte_q [$];

  // One result transfer as seen on the output channel.
  typedef struct packed {
    logic              char_valid;
    logic [CHAR_W-1:0] out_char;
    logic              token_end;
    logic              string_done;
  } tok_result_t;

  // Tracks the parser state and separator set, predicts one result per
  // accepted byte and compares each result transfer against the oldest one.
  class token_scoreboard;
    mode_t          mode;
    int unsigned    tok_len;
    bit [2:0]       sep_count;
    bit [7:0]       seps [SEP_NUM];
    tok_result_t    expected_q [$];
    int             errors;

    function new();
      mode      = MODE_IDLE;
      tok_len   = 0;
      sep_count = SEP_COUNT_RST;
      foreach (seps[i]) seps[i] = 8'h00;
      seps[0]   = SEP_CHAR0_RST;
      seps[1]   = SEP_CHAR1_RST;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CHAR_W-1:0] val);
      if (idx == REG_SEP_COUNT) begin
        sep_count = val[2:0];
      end else if (idx >= REG_SEP_CHAR0 && idx <= REG_SEP_CHAR5) begin
        seps[idx - REG_SEP_CHAR0] = val;
      end
    endfunction

    function bit is_separator(logic [CHAR_W-1:0] c);
      int n;
      n = (sep_count > 3'd6) ? 6 : int'(sep_count);
      for (int i = 0; i < n; i++) begin
        if (seps[i] == c) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Append a byte to the current token unless it is already at the cap.
    function void take(logic [CHAR_W-1:0] c, inout tok_result_t r);
      if (tok_len < MAX_TOKEN_LEN) begin
        tok_len++;
        r.char_valid = 1'b1;
        r.out_char   = c;
      end
    endfunction

    function void end_token(mode_t next, inout tok_result_t r);
      r.token_end = 1'b1;
      tok_len     = 0;
      mode        = next;
    endfunction

    function void note_byte(logic [CHAR_W-1:0] c, logic is_last);
      tok_result_t r;
      r = '0;
      case (mode)
        MODE_IDLE: begin
          // a quote beats a separator that happens to hold a quote
          if (c == CH_QUOTE) begin
            mode = MODE_QUOTE;
          end else if (!is_separator(c)) begin
            take(c, r);
            mode = MODE_PLAIN;
          end
        end
        MODE_PLAIN: begin
          if (is_separator(c)) begin
            end_token(MODE_IDLE, r);
          end else if (c == CH_QUOTE) begin
            end_token(MODE_QUOTE, r);
          end else begin
            take(c, r);
          end
        end
        MODE_QUOTE: begin
          if (c == CH_QUOTE || c == CH_LF || c == CH_CR) begin
            end_token(MODE_IDLE, r);
          end else if (c == CH_BSLASH) begin
            mode = MODE_ESC;
          end else begin
            take(c, r);
          end
        end
        default: begin
          mode = MODE_QUOTE;
          if (c == CH_BSLASH || c == CH_QUOTE) take(c, r);
          else if (c == CH_LOW_R) take(CH_CR, r);
          else if (c == CH_LOW_N) take(CH_LF, r);
          else if (c == CH_LOW_T) take(CH_TAB, r);
          else if (c == CH_LOW_A) take(CH_BEL, r);
        end
      endcase
      if (is_last) begin
        if (mode != MODE_IDLE && tok_len > 0) r.token_end = 1'b1;
        mode    = MODE_IDLE;
        tok_len = 0;
      end
      r.string_done = is_last;
      expected_q.push_back(r);
    endfunction

    function void check_result(tok_result_t got);
      tok_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer: %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.char_valid !== want.char_valid || got.out_char !== want.out_char ||
          got.token_end !== want.token_end || got.string_done !== want.string_done) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp cv=%0b ch=%h end=%0b done=%0b  got cv=%0b ch=%h end=%0b done=%0b",
                   want.char_valid, want.out_char, want.token_end, want.string_done,
                   got.char_valid, got.out_char, got.token_end, got.string_done);
        end
      end
    endfunction

    function void check_empty();
      if (expected_q.size() > 0) begin
        errors++;
        if (errors <= 10) $display("%0d results never arrived", expected_q.size());
      end
    endfunction
  endclass

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CHAR_W-1:0]    cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic [CHAR_W-1:0]    in_char     = 8'h01;
  logic                 last        = 1'b0;
  logic                 out_stall   = 1'b0;
  wire logic            in_stall;
  wire logic            out_valid;
  wire logic            char_valid;
  wire logic [CHAR_W-1:0] out_char;
  wire logic            token_end;
  wire logic            string_done;

  // Both sides skip idling altogether while calm is set (redrawn per command line).
  bit                   calm       = 1'b0;
  int                   out_hold   = 0;
  int                   cycles     = 0;

  token_scoreboard sb = new();

  quoted_command_tokenizer dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_char     (in_char),
    .last        (last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_valid  (char_valid),
    .out_char    (out_char),
    .token_end   (token_end),
    .string_done (string_done)
  );

  always #1 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int draw_wait();
    return calm ? 0 : int'($urandom_range(0, 7));
  endfunction

  // Result side: check every transfer, then hold stall high for a random
  // number of cycles. Stall cycles also land while nothing is valid.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_hold  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_result('{char_valid, out_char, token_end, string_done});
        out_hold = draw_wait();
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Sender: optional gap, then hold the byte until a transfer happens.
  // With no gap, valid stays high straight into the next byte.
  task automatic send_byte(input logic [CHAR_W-1:0] c, input logic is_last);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    last     <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(c, is_last);
  endtask

  task automatic send_line(input byte_q q);
    calm = ($urandom_range(0, 3) == 0);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // Wait out every expected result plus the pipeline depth.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Each write lowers the enable again and waits, so the enable never drops and rises in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHAR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  function automatic void add_text(ref byte_q q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic logic [CHAR_W-1:0] letter();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [CHAR_W-1:0] any_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  // Separator byte for a register: mostly the usual punctuation, sometimes
  // awkward choices (quote, backslash, CR, zero, anything).
  function automatic logic [CHAR_W-1:0] pick_sep_value();
    logic [CHAR_W-1:0] usual [6];
    int r;
    usual = '{8'h20, CH_TAB, 8'h2C, 8'h3B, 8'h7C, 8'h3A};
    r = $urandom_range(0, 19);
    if (r < 12) return usual[r % 6];
    if (r < 16) return any_byte();
    if (r == 16) return CH_QUOTE;
    if (r == 17) return CH_BSLASH;
    if (r == 18) return CH_CR;
    return 8'h00;
  endfunction

  // A separator that is active right now, or a space if none is.
  function automatic logic [CHAR_W-1:0] pick_sep();
    int n;
    n = (sb.sep_count > 3'd6) ? 6 : int'(sb.sep_count);
    if (n == 0 || $urandom_range(0, 9) == 0) return 8'h20;
    return sb.seps[$urandom_range(0, n - 1)];
  endfunction

  // Mostly well-formed command lines: plain words and quoted words with
  // escapes, split by active separators, with some noise and broken quotes.
  function automatic void build_command(ref byte_q q);
    logic [CHAR_W-1:0] esc_set [7];
    int parts, kind, len, r;
    esc_set = '{CH_BSLASH, CH_QUOTE, CH_LOW_R, CH_LOW_N, CH_LOW_T, CH_LOW_A, 8'h00};
    q = {};
    parts = $urandom_range(1, 5);
    for (int p = 0; p < parts; p++) begin
      if (p > 0 || $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) q.push_back(pick_sep());
      end
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        len = $urandom_range(1, 8);
        repeat (len) q.push_back(($urandom_range(0, 4) == 0) ? any_byte() : letter());
      end else if (kind <= 7) begin
        q.push_back(CH_QUOTE);
        len = $urandom_range(0, 6);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) begin
            q.push_back(CH_BSLASH);
            r = $urandom_range(0, 6);
            q.push_back((r == 6) ? any_byte() : esc_set[r]);
          end else begin
            q.push_back(letter());
          end
        end
        // usually closed by a quote; sometimes by a line end, sometimes left open
        r = $urandom_range(0, 9);
        if (r <= 6) q.push_back(CH_QUOTE);
        else if (r == 7) q.push_back(CH_CR);
        else if (r == 8) q.push_back(CH_LF);
      end else if (kind == 8) begin
        q.push_back(CH_QUOTE);
        q.push_back(CH_QUOTE);
      end else begin
        repeat ($urandom_range(1, 4)) q.push_back(any_byte());
      end
    end
    if ($urandom_range(0, 4) == 0) q.push_back(pick_sep());
  endfunction

  task automatic random_config(input int phase);
    logic [2:0] cnt;
    // first phases pin separator counts of seven, one and six
    if (phase == 0) cnt = 3'd7;
    else if (phase == 1) cnt = 3'd1;
    else if (phase == 2) cnt = 3'd6;
    else cnt = 3'($urandom_range(0, 7));
    write_reg(REG_SEP_COUNT, {5'($urandom), cnt});
    for (int i = 0; i < SEP_NUM; i++) begin
      write_reg(3'(REG_SEP_CHAR0 + i), pick_sep_value());
    end
    if ($urandom_range(0, 1) == 0) write_reg(REG_NONE, 8'($urandom));
  endtask

  initial begin
    byte_q q;
    int sent;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset separators (space, TAB): TAB split, every escape,
    // an unknown escape, closing quote.
    q = {};
    add_text(q, "a");
    q.push_back(CH_TAB);
    q.push_back(CH_QUOTE);
    add_text(q, "\\n\\q\\\"\\\\\\r\\t\\a");
    q.push_back(CH_QUOTE);
    send_line(q);
    // empty quoted pair, quote ending a plain word, CR ending a quote
    q = {};
    add_text(q, "\"\" x\"y");
    q.push_back(CH_CR);
    send_line(q);
    // LF ending a quote, last byte on a separator
    q = {};
    add_text(q, "\"z");
    q.push_back(CH_LF);
    add_text(q, "w ");
    send_line(q);
    // byte extremes, then an empty quote left open at the last byte
    q = '{8'hFF, 8'h01, CH_QUOTE};
    send_line(q);
    // open quote with content at the last byte closes the token
    q = {};
    add_text(q, "\"q");
    send_line(q);
    drain();

    // Count above six, quote and zero as separators, write to a missing index.
    write_reg(REG_SEP_COUNT, 8'hFF);
    write_reg(REG_SEP_CHAR0, CH_QUOTE);
    write_reg(3'(REG_SEP_CHAR0 + 1), 8'h00);
    write_reg(3'(REG_SEP_CHAR0 + 2), 8'hFF);
    write_reg(3'(REG_SEP_CHAR0 + 3), CH_BSLASH);
    write_reg(3'(REG_SEP_CHAR0 + 4), 8'h2C);
    write_reg(REG_SEP_CHAR5, 8'h78);
    write_reg(REG_NONE, 8'h5A);
    q = {};
    add_text(q, "\"k\\x\"m\"");
    q.push_back(8'h00);
    add_text(q, "n");
    q.push_back(8'hFF);
    add_text(q, ",px");
    send_line(q);
    drain();

    // No separators at all.
    write_reg(REG_SEP_COUNT, 8'h00);
    q = {};
    add_text(q, "a b");
    q.push_back(CH_TAB);
    add_text(q, "\"c\"");
    send_line(q);
    drain();

    // Token length cap: a long plain word, a long quoted word whose escapes
    // straddle the cap, and a long word still open at the last byte.
    write_reg(REG_SEP_COUNT, SEP_COUNT_RST);
    write_reg(REG_SEP_CHAR0, SEP_CHAR0_RST);
    write_reg(3'(REG_SEP_CHAR0 + 1), SEP_CHAR1_RST);
    q = {};
    repeat (MAX_TOKEN_LEN + 6) q.push_back(letter());
    q.push_back(8'h20);
    q.push_back(CH_QUOTE);
    repeat (MAX_TOKEN_LEN - 4) q.push_back(letter());
    repeat (8) begin
      q.push_back(CH_BSLASH);
      q.push_back(CH_LOW_N);
    end
    q.push_back(CH_QUOTE);
    repeat (MAX_TOKEN_LEN + 6) q.push_back(letter());
    send_line(q);
    drain();

    // Random command lines under several separator settings.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_config(ph);
      sent = 0;
      while (sent < BYTES_PER_PHASE) begin
        build_command(q);
        send_line(q);
        sent += q.size();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    sb.check_empty();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
